// ----- sv/vcsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsd_pkg
// Types and constants of the vehicle CAN signal decoder: beat payloads,
// frame identifiers and lengths, raw value windows and register map.
// ----------------------------------------------------------------------------
package vcsd_pkg;

  // Input beat: one received standard CAN frame
  typedef struct packed {
    logic [10:0] frame_ident;
    logic [3:0]  frame_length;
    logic [63:0] frame_bytes;
  } req_t;

  // Output beat: frame status and all held readings
  typedef struct packed {
    logic              frame_valid;
    logic [7:0]        gear_now;
    logic [7:0]        throttle_now;
    logic [14:0]       engine_rpm;
    logic [11:0]       road_speed;
    logic [6:0]        coolant_temp;
    logic signed [7:0] intake_temp;
    logic              alert_flag;
  } rsp_t;

  // Frame identifiers
  localparam logic [10:0] ID_ENGINE   = 11'h20A;
  localparam logic [10:0] ID_THROTTLE = 11'h216;
  localparam logic [10:0] ID_STATUS   = 11'h22E;
  localparam logic [10:0] ID_GEAR     = 11'h236;
  localparam logic [10:0] ID_DIAG     = 11'h23A;
  localparam logic [10:0] ID_TEMPS    = 11'h23E;

  // Required data lengths
  localparam logic [3:0] LEN_ENGINE   = 4'd8;
  localparam logic [3:0] LEN_THROTTLE = 4'd7;
  localparam logic [3:0] LEN_STATUS   = 4'd2;
  localparam logic [3:0] LEN_GEAR     = 4'd1;
  localparam logic [3:0] LEN_DIAG     = 4'd3;
  localparam logic [3:0] LEN_TEMPS    = 4'd4;

  // Scale factors
  localparam logic [14:0] RPM_SCALE   = 15'd100;
  localparam logic [11:0] SPEED_SCALE = 12'd10;

  // Gear code for blank display
  localparam logic [7:0] GEAR_RAW_BLANK = 8'hE0;
  localparam logic [7:0] GEAR_BLANK     = 8'hFF;

  // Diagnostic byte masks
  localparam logic [7:0] DIAG_ALERT_MASK = 8'h0C;
  localparam logic [7:0] DIAG_HIGH_MASK  = 8'hF0;

  // Temperature raw windows and offsets; 625/1000 is exactly 5/8
  localparam logic [7:0] COOL_RAW_LO   = 8'h70;
  localparam logic [7:0] COOL_RAW_HI   = 8'hEA;
  localparam logic [6:0] COOL_BASE     = 7'd40;
  localparam logic [7:0] AIR_RAW_LO    = 8'h21;
  localparam logic [7:0] AIR_RAW_HI    = 8'hCF;
  localparam logic [7:0] AIR_BASE_NEG  = 8'd9;
  localparam logic [3:0] TEMP_MUL      = 4'd5;
  localparam int         TEMP_SHIFT    = 3;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_THR_MIN  = 2'd0;
  localparam logic [1:0] REG_THR_MAX  = 2'd1;
  localparam logic [1:0] REG_THR_GAIN = 2'd2;

  localparam logic [7:0]  THR_MIN_RST  = 8'd34;
  localparam logic [7:0]  THR_MAX_RST  = 8'd206;
  localparam logic [15:0] THR_GAIN_RST = 16'd381;

  // Output ranges
  localparam logic [7:0]        GEAR_TOP    = 8'd6;
  localparam logic [6:0]        COOL_TOP    = 7'd116;
  localparam logic signed [7:0] AIR_BOTTOM  = -8'sd9;
  localparam logic signed [7:0] AIR_TOP     = 8'sd99;

endpackage

// ----- sv/vehicle_can_signal_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_can_signal_decoder_unit
// Decodes received CAN frames into held vehicle readings.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one frame per beat.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one beat per frame:
//   the frame-valid flag and every held reading after that frame.
//   APB port sets throttle_raw_min (0x0), throttle_raw_max (0x4) and
//   throttle_gain (0x8); write only while no frame is in flight.
// Timing:
//   A frame is held in the input register, where the decode runs
//   against the held readings, then lands in the result register once
//   that register is empty or being taken. One frame per cycle is
//   sustained while rsp_ready stays high; the held readings feed back alone.
// Reset:
//   rst (synchronous) empties both registers, clears the held readings and
//   loads the throttle registers with 34, 206 and 381.
// Stall:
//   While rsp_ready is low the result holds; the input register still
//   takes one more frame, then req_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module vehicle_can_signal_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  vcsd_pkg::req_t     req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output vcsd_pkg::rsp_t     rsp_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers
  logic [7:0]  thr_min;
  logic [7:0]  thr_max;
  logic [15:0] thr_gain;

  // Input register
  logic           s1_valid;
  vcsd_pkg::req_t s1_item;

  // Held readings
  logic [7:0]  held_gear,     held_gear_next;
  logic [7:0]  held_throttle, held_throttle_next;
  logic [14:0] held_rpm,      held_rpm_next;
  logic [11:0] held_speed,    held_speed_next;
  logic [6:0]  held_coolant,  held_coolant_next;
  logic [7:0]  held_intake,   held_intake_next;
  logic        held_alert,    held_alert_next;
  logic        ok;

  logic        advance;
  logic        cfg_write;

  logic [7:0]  b0, b1, b2, b3, b4;
  logic [7:0]  thr_diff;
  logic [23:0] thr_prod;
  logic        thr_in;
  logic [6:0]  cool_off;
  logic [10:0] cool_scaled;
  logic [7:0]  air_off;
  logic [11:0] air_scaled;
  logic        cool_ok, air_ok;

  vcsd_pkg::rsp_t result;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_min  <= vcsd_pkg::THR_MIN_RST;
      thr_max  <= vcsd_pkg::THR_MAX_RST;
      thr_gain <= vcsd_pkg::THR_GAIN_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        vcsd_pkg::REG_THR_MIN:  thr_min  <= pwdata[7:0];
        vcsd_pkg::REG_THR_MAX:  thr_max  <= pwdata[7:0];
        vcsd_pkg::REG_THR_GAIN: thr_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      vcsd_pkg::REG_THR_MIN:  prdata = {24'd0, thr_min};
      vcsd_pkg::REG_THR_MAX:  prdata = {24'd0, thr_max};
      vcsd_pkg::REG_THR_GAIN: prdata = {16'd0, thr_gain};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_item <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_gear     <= '0;
      held_throttle <= '0;
      held_rpm      <= '0;
      held_speed    <= '0;
      held_coolant  <= '0;
      held_intake   <= '0;
      held_alert    <= 1'b0;
    end else if (advance) begin
      held_gear     <= held_gear_next;
      held_throttle <= held_throttle_next;
      held_rpm      <= held_rpm_next;
      held_speed    <= held_speed_next;
      held_coolant  <= held_coolant_next;
      held_intake   <= held_intake_next;
      held_alert    <= held_alert_next;
    end
  end

  // ---------------- decode ----------------
  assign b0 = s1_item.frame_bytes[7:0];
  assign b1 = s1_item.frame_bytes[15:8];
  assign b2 = s1_item.frame_bytes[23:16];
  assign b3 = s1_item.frame_bytes[31:24];
  assign b4 = s1_item.frame_bytes[39:32];

  // Throttle: keep the upper byte of the low 16 product bits
  assign thr_in   = (b0 >= thr_min) && (b0 <= thr_max);
  assign thr_diff = b0 - thr_min;
  assign thr_prod = {16'd0, thr_diff} * {8'd0, thr_gain};

  assign cool_ok     = (b0 >= vcsd_pkg::COOL_RAW_LO) && (b0 <= vcsd_pkg::COOL_RAW_HI);
  assign air_ok      = (b1 >= vcsd_pkg::AIR_RAW_LO) && (b1 <= vcsd_pkg::AIR_RAW_HI);
  assign cool_off    = 7'(b0 - vcsd_pkg::COOL_RAW_LO);
  assign air_off     = b1 - vcsd_pkg::AIR_RAW_LO;
  assign cool_scaled = {4'd0, cool_off} * {7'd0, vcsd_pkg::TEMP_MUL};
  assign air_scaled  = {4'd0, air_off} * {8'd0, vcsd_pkg::TEMP_MUL};

  always_comb begin
    held_gear_next     = held_gear;
    held_throttle_next = held_throttle;
    held_rpm_next      = held_rpm;
    held_speed_next    = held_speed;
    held_coolant_next  = held_coolant;
    held_intake_next   = held_intake;
    held_alert_next    = held_alert;
    ok                 = 1'b0;

    unique case (s1_item.frame_ident)
      vcsd_pkg::ID_ENGINE: begin
        if (s1_item.frame_length == vcsd_pkg::LEN_ENGINE) begin
          held_rpm_next   = {7'd0, b2} * vcsd_pkg::RPM_SCALE;
          held_speed_next = {4'd0, b4} * vcsd_pkg::SPEED_SCALE;
          ok              = 1'b1;
        end
      end
      vcsd_pkg::ID_THROTTLE: begin
        if (s1_item.frame_length == vcsd_pkg::LEN_THROTTLE) begin
          ok = 1'b1;
          if (thr_in) begin
            held_throttle_next = (b0 == thr_max) ? 8'hFF : thr_prod[15:8];
          end
        end
      end
      vcsd_pkg::ID_STATUS: begin
        if (s1_item.frame_length == vcsd_pkg::LEN_STATUS) begin
          ok = (b0 == 8'd0) && (b1 == 8'd0);
        end
      end
      vcsd_pkg::ID_GEAR: begin
        if (s1_item.frame_length == vcsd_pkg::LEN_GEAR && b0[4:0] == 5'd0) begin
          ok             = 1'b1;
          held_gear_next = (b0 == vcsd_pkg::GEAR_RAW_BLANK) ? vcsd_pkg::GEAR_BLANK
                                                            : {5'd0, b0[7:5]};
        end
      end
      vcsd_pkg::ID_DIAG: begin
        if (s1_item.frame_length == vcsd_pkg::LEN_DIAG) begin
          held_alert_next = |(b0 & vcsd_pkg::DIAG_ALERT_MASK);
          ok = ((b0 & vcsd_pkg::DIAG_HIGH_MASK) == 8'd0) && (b1 == 8'hFF) && (b2 == 8'hFF);
        end
      end
      vcsd_pkg::ID_TEMPS: begin
        if (s1_item.frame_length == vcsd_pkg::LEN_TEMPS) begin
          // store each temperature on its own when in its window
          if (cool_ok) begin
            held_coolant_next = vcsd_pkg::COOL_BASE
                                + 7'(cool_scaled >> vcsd_pkg::TEMP_SHIFT);
          end
          if (air_ok) begin
            held_intake_next = 8'(air_scaled >> vcsd_pkg::TEMP_SHIFT)
                               - vcsd_pkg::AIR_BASE_NEG;
          end
          ok = cool_ok && air_ok && (b2 == 8'd0) && (b3 == 8'd0);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.frame_valid  = ok;
    result.gear_now     = held_gear_next;
    result.throttle_now = held_throttle_next;
    result.engine_rpm   = held_rpm_next;
    result.road_speed   = held_speed_next;
    result.coolant_temp = held_coolant_next;
    result.intake_temp  = $signed(held_intake_next);
    result.alert_flag   = held_alert_next;
  end

endmodule

// ----- sv/vcsd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsd_checker
// Port-level checks of the CAN signal decoder, bound to the top level.
// ----------------------------------------------------------------------------
module vcsd_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input vcsd_pkg::rsp_t rsp_data
);

  // No result beat right after reset
  a_rsp_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result beat present right after reset");

  // Stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result beat changed or dropped");

  // Gear is neutral, a gear, or blank
  a_gear_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.gear_now <= vcsd_pkg::GEAR_TOP) ||
                  (rsp_data.gear_now == vcsd_pkg::GEAR_BLANK))
    else $error("gear reading out of range");

  // Temperatures stay at reset value or inside their decoded windows
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_data.coolant_temp == 7'd0) ||
                   ((rsp_data.coolant_temp >= vcsd_pkg::COOL_BASE) &&
                    (rsp_data.coolant_temp <= vcsd_pkg::COOL_TOP))) &&
                  ((rsp_data.intake_temp >= vcsd_pkg::AIR_BOTTOM) &&
                   (rsp_data.intake_temp <= vcsd_pkg::AIR_TOP)))
    else $error("temperature reading out of range");

endmodule

bind vehicle_can_signal_decoder_unit vcsd_checker u_vcsd_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vehicle CAN signal decoder unit. Frames of
// every known identifier, with broken lengths and unknown identifiers mixed
// in, are pushed through the block under several throttle window settings.
// A scoreboard keeps its own copy of the held readings, predicts each
// result beat, and compares it field by field with the beat that comes out.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_SET = 130;
  localparam int MAX_PRINTED   = 40;

  class can_reading_scoreboard;
    logic [7:0]  thr_min;
    logic [7:0]  thr_max;
    logic [15:0] thr_gain;
    logic [7:0]  gear;
    logic [7:0]  throttle;
    logic [14:0] rpm;
    logic [11:0] speed;
    logic [6:0]  coolant;
    logic [7:0]  intake;
    logic        alert;
    vcsd_pkg::rsp_t readings_due[$];
    int          errors;
    int          frames;
    int          results;
    int          valid_seen;

    function new();
      thr_min  = vcsd_pkg::THR_MIN_RST;
      thr_max  = vcsd_pkg::THR_MAX_RST;
      thr_gain = vcsd_pkg::THR_GAIN_RST;
      gear = '0; throttle = '0; rpm = '0; speed = '0;
      coolant = '0; intake = '0; alert = 1'b0;
      errors = 0; frames = 0; results = 0; valid_seen = 0;
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    // Update the held readings from one accepted frame and queue the beat
    function void note_frame(vcsd_pkg::req_t f);
      logic [7:0] b0, b1, b2, b3, b4;
      logic       ok, cool_ok, air_ok;
      int         p;
      vcsd_pkg::rsp_t r;
      b0 = f.frame_bytes[7:0];
      b1 = f.frame_bytes[15:8];
      b2 = f.frame_bytes[23:16];
      b3 = f.frame_bytes[31:24];
      b4 = f.frame_bytes[39:32];
      ok = 1'b0;
      frames++;
      case (f.frame_ident)
        vcsd_pkg::ID_ENGINE: if (f.frame_length == vcsd_pkg::LEN_ENGINE) begin
          rpm   = 15'(int'(b2) * 100);
          speed = 12'(int'(b4) * 10);
          ok    = 1'b1;
        end
        vcsd_pkg::ID_THROTTLE: if (f.frame_length == vcsd_pkg::LEN_THROTTLE) begin
          // skip raw bytes outside the window without flagging the frame
          if (b0 >= thr_min && b0 <= thr_max) begin
            if (b0 == thr_max) begin
              throttle = 8'd255;
            end else begin
              p        = (int'(b0) - int'(thr_min)) * int'(thr_gain);
              throttle = p[15:8];
            end
          end
          ok = 1'b1;
        end
        vcsd_pkg::ID_STATUS: if (f.frame_length == vcsd_pkg::LEN_STATUS) begin
          ok = (b0 == 8'd0) && (b1 == 8'd0);
        end
        vcsd_pkg::ID_GEAR: if (f.frame_length == vcsd_pkg::LEN_GEAR) begin
          if (b0[4:0] == 5'd0) begin
            gear = (b0 == vcsd_pkg::GEAR_RAW_BLANK) ? vcsd_pkg::GEAR_BLANK
                                                    : {5'd0, b0[7:5]};
            ok   = 1'b1;
          end
        end
        vcsd_pkg::ID_DIAG: if (f.frame_length == vcsd_pkg::LEN_DIAG) begin
          alert = (b0 & vcsd_pkg::DIAG_ALERT_MASK) != 8'd0;
          ok    = ((b0 & vcsd_pkg::DIAG_HIGH_MASK) == 8'd0) && (b1 == 8'hFF) &&
                  (b2 == 8'hFF);
        end
        vcsd_pkg::ID_TEMPS: if (f.frame_length == vcsd_pkg::LEN_TEMPS) begin
          cool_ok = (b0 >= vcsd_pkg::COOL_RAW_LO) && (b0 <= vcsd_pkg::COOL_RAW_HI);
          air_ok  = (b1 >= vcsd_pkg::AIR_RAW_LO) && (b1 <= vcsd_pkg::AIR_RAW_HI);
          if (cool_ok)
            coolant = 7'(40 + (int'(b0) - int'(vcsd_pkg::COOL_RAW_LO)) * 625 / 1000);
          if (air_ok) begin
            p      = (int'(b1) - int'(vcsd_pkg::AIR_RAW_LO)) * 625 / 1000 - 9;
            intake = p[7:0];
          end
          ok = cool_ok && air_ok && (b2 == 8'd0) && (b3 == 8'd0);
        end
        default: ;
      endcase
      r.frame_valid  = ok;
      r.gear_now     = gear;
      r.throttle_now = throttle;
      r.engine_rpm   = rpm;
      r.road_speed   = speed;
      r.coolant_temp = coolant;
      r.intake_temp  = intake;
      r.alert_flag   = alert;
      readings_due.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task compare_field(string what, int got, int want);
      if (got != want) report_mismatch(what, got, want);
    endtask

    task check_result(vcsd_pkg::rsp_t got);
      vcsd_pkg::rsp_t want;
      results++;
      if (readings_due.size() == 0) begin
        report_mismatch("result beat with no frame pending", results, 0);
      end else begin
        want = readings_due.pop_front();
        if (got.frame_valid) valid_seen++;
        compare_field("frame_valid", int'(got.frame_valid), int'(want.frame_valid));
        compare_field("gear_now", int'(got.gear_now), int'(want.gear_now));
        compare_field("throttle_now", int'(got.throttle_now), int'(want.throttle_now));
        compare_field("engine_rpm", int'(got.engine_rpm), int'(want.engine_rpm));
        compare_field("road_speed", int'(got.road_speed), int'(want.road_speed));
        compare_field("coolant_temp", int'(got.coolant_temp), int'(want.coolant_temp));
        compare_field("intake_temp", int'(got.intake_temp), int'(want.intake_temp));
        compare_field("alert_flag", int'(got.alert_flag), int'(want.alert_flag));
      end
    endtask
  endclass

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  vcsd_pkg::req_t req_data  = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  vcsd_pkg::rsp_t rsp_data;
  logic           psel      = 1'b0;
  logic           penable   = 1'b0;
  logic           pwrite    = 1'b0;
  logic [3:0]     paddr     = '0;
  logic [31:0]    pwdata    = '0;
  logic [31:0]    prdata;
  logic           pready;

  can_reading_scoreboard sb;
  int burst_left   = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int settings_run = 0;

  vehicle_can_signal_decoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Note accepted frames before checking results so ordering stays fixed
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_frame(req_data);
      if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("vehicle_can_signal_decoder_unit: mismatch");
    $finish;
  end

  // Receiver: stall pattern in random modes, plus long hold-offs on request
  initial begin
    int mode_left;
    int stall_pct;
    int hold_left;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != holds_asked) begin
        holds_served++;
        hold_left = $urandom_range(150, 300);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic vcsd_pkg::req_t frame_of(logic [10:0] id, logic [3:0] len,
                                              logic [63:0] data);
    vcsd_pkg::req_t f;
    f.frame_ident  = id;
    f.frame_length = len;
    f.frame_bytes  = data;
    return f;
  endfunction

  // Mostly well-formed frames with random content; some broken or unknown
  function automatic vcsd_pkg::req_t random_frame();
    vcsd_pkg::req_t f;
    int         pick;
    logic [2:0] g;
    pick          = $urandom_range(0, 99);
    f.frame_bytes = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: begin
        f.frame_ident  = vcsd_pkg::ID_ENGINE;
        f.frame_length = vcsd_pkg::LEN_ENGINE;
      end
      1: begin
        f.frame_ident  = vcsd_pkg::ID_THROTTLE;
        f.frame_length = vcsd_pkg::LEN_THROTTLE;
        if ($urandom_range(0, 1) && sb.thr_min <= sb.thr_max)
          f.frame_bytes[7:0] = 8'($urandom_range(sb.thr_min, sb.thr_max));
      end
      2: begin
        f.frame_ident  = vcsd_pkg::ID_STATUS;
        f.frame_length = vcsd_pkg::LEN_STATUS;
        if ($urandom_range(0, 1)) f.frame_bytes[15:0] = '0;
      end
      3: begin
        f.frame_ident  = vcsd_pkg::ID_GEAR;
        f.frame_length = vcsd_pkg::LEN_GEAR;
        g = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 7) f.frame_bytes[7:0] = {g, 5'd0};
      end
      4: begin
        f.frame_ident  = vcsd_pkg::ID_DIAG;
        f.frame_length = vcsd_pkg::LEN_DIAG;
        if ($urandom_range(0, 9) < 6) f.frame_bytes[23:0] = {16'hFFFF, 4'h0, 4'($urandom)};
      end
      default: begin
        f.frame_ident  = vcsd_pkg::ID_TEMPS;
        f.frame_length = vcsd_pkg::LEN_TEMPS;
        if ($urandom_range(0, 9) < 7)
          f.frame_bytes[7:0] = 8'($urandom_range(vcsd_pkg::COOL_RAW_LO, vcsd_pkg::COOL_RAW_HI));
        if ($urandom_range(0, 9) < 7)
          f.frame_bytes[15:8] = 8'($urandom_range(vcsd_pkg::AIR_RAW_LO, vcsd_pkg::AIR_RAW_HI));
        if ($urandom_range(0, 9) < 7) f.frame_bytes[31:16] = '0;
      end
    endcase
    if (pick >= 95) begin
      f.frame_ident  = 11'($urandom);
      f.frame_length = 4'($urandom);
    end else if (pick >= 85) begin
      f.frame_length = 4'($urandom_range(0, 15));
    end
    return f;
  endfunction

  task automatic sender_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  // Hold the beat until it is taken
  task automatic send_frame(vcsd_pkg::req_t f);
    @(negedge clk);
    req_valid <= 1'b1;
    req_data  <= f;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic offer_frame(vcsd_pkg::req_t f);
    if (burst_left == 0) begin
      sender_gap($urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_frame(f);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_throttle_window(logic [7:0] lo, logic [7:0] hi, logic [15:0] gain);
    wait_drained();
    repeat (4) @(posedge clk);
    apb_write(vcsd_pkg::REG_THR_MIN, {24'd0, lo});
    apb_write(vcsd_pkg::REG_THR_MAX, {24'd0, hi});
    apb_write(vcsd_pkg::REG_THR_GAIN, {16'd0, gain});
    sb.thr_min  = lo;
    sb.thr_max  = hi;
    sb.thr_gain = gain;
    settings_run++;
  endtask

  task automatic run_random_set(int set_idx);
    for (int i = 0; i < ITEMS_PER_SET; i++) begin
      // starve the output so the block backs up into its input
      if (i == 40 && set_idx % 2 == 0) holds_asked++;
      if (i == 80 && set_idx % 2 == 1) wait_drained();
      offer_frame(random_frame());
    end
  endtask

  initial begin
    vcsd_pkg::req_t opening[$];
    int   lo;
    int   hi;
    sb = new();
    opening.push_back(frame_of(vcsd_pkg::ID_ENGINE, vcsd_pkg::LEN_ENGINE, '1));
    opening.push_back(frame_of(vcsd_pkg::ID_ENGINE, vcsd_pkg::LEN_ENGINE, '0));
    opening.push_back(frame_of(vcsd_pkg::ID_ENGINE, 4'd9, 64'h0000_0055_0055_0000));
    opening.push_back(frame_of(vcsd_pkg::ID_ENGINE, 4'd7, 64'h0000_0011_0022_0000));
    opening.push_back(frame_of(vcsd_pkg::ID_THROTTLE, vcsd_pkg::LEN_THROTTLE, 64'd34));
    opening.push_back(frame_of(vcsd_pkg::ID_THROTTLE, vcsd_pkg::LEN_THROTTLE, 64'd206));
    opening.push_back(frame_of(vcsd_pkg::ID_THROTTLE, vcsd_pkg::LEN_THROTTLE, 64'd33));
    opening.push_back(frame_of(vcsd_pkg::ID_THROTTLE, vcsd_pkg::LEN_THROTTLE, 64'd207));
    opening.push_back(frame_of(vcsd_pkg::ID_THROTTLE, vcsd_pkg::LEN_THROTTLE, 64'd120));
    opening.push_back(frame_of(vcsd_pkg::ID_STATUS, vcsd_pkg::LEN_STATUS, 64'h0));
    opening.push_back(frame_of(vcsd_pkg::ID_STATUS, vcsd_pkg::LEN_STATUS, 64'h0100));
    opening.push_back(frame_of(vcsd_pkg::ID_GEAR, vcsd_pkg::LEN_GEAR, 64'hC0));
    opening.push_back(frame_of(vcsd_pkg::ID_GEAR, vcsd_pkg::LEN_GEAR, 64'hE0));
    opening.push_back(frame_of(vcsd_pkg::ID_GEAR, vcsd_pkg::LEN_GEAR, 64'h21));
    opening.push_back(frame_of(vcsd_pkg::ID_GEAR, vcsd_pkg::LEN_GEAR, 64'h60));
    opening.push_back(frame_of(vcsd_pkg::ID_GEAR, vcsd_pkg::LEN_GEAR, 64'h00));
    opening.push_back(frame_of(vcsd_pkg::ID_DIAG, vcsd_pkg::LEN_DIAG, 64'hFF_FF0C));
    opening.push_back(frame_of(vcsd_pkg::ID_DIAG, vcsd_pkg::LEN_DIAG, 64'hFF_FF10));
    opening.push_back(frame_of(vcsd_pkg::ID_DIAG, vcsd_pkg::LEN_DIAG, 64'hFE_FF04));
    opening.push_back(frame_of(vcsd_pkg::ID_TEMPS, vcsd_pkg::LEN_TEMPS, 64'h0000_2170));
    opening.push_back(frame_of(vcsd_pkg::ID_TEMPS, vcsd_pkg::LEN_TEMPS, 64'h0000_CFEA));
    opening.push_back(frame_of(vcsd_pkg::ID_TEMPS, vcsd_pkg::LEN_TEMPS, 64'h0000_D06F));
    opening.push_back(frame_of(vcsd_pkg::ID_TEMPS, vcsd_pkg::LEN_TEMPS, 64'h0100_5080));
    opening.push_back(frame_of(11'h7FF, 4'hF, '1));
    opening.push_back(frame_of(11'h000, 4'h0, '0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[k]) offer_frame(opening[k]);

    load_throttle_window(8'd34, 8'd206, 16'd381);
    run_random_set(0);
    load_throttle_window(8'd0, 8'd255, 16'd257);
    run_random_set(1);
    load_throttle_window(8'd0, 8'd128, 16'd512);
    run_random_set(2);
    load_throttle_window(8'd100, 8'd101, 16'd65535);
    run_random_set(3);
    // window upside down: throttle must never move
    load_throttle_window(8'd200, 8'd100, 16'd1234);
    run_random_set(4);
    load_throttle_window(8'd255, 8'd255, 16'd0);
    run_random_set(5);
    load_throttle_window(8'd0, 8'd0, 16'd65535);
    run_random_set(6);
    for (int s = 7; s < 9; s++) begin
      lo = $urandom_range(0, 200);
      hi = $urandom_range(lo + 1, 255);
      load_throttle_window(lo[7:0], hi[7:0], 16'(65536 / (hi - lo)));
      run_random_set(s);
    end

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d frames (%0d flagged valid) over %0d throttle window settings,",
             sb.frames, sb.valid_seen, settings_run);
    $display("with %0d result beats checked and %0d long output stalls.",
             sb.results, holds_served);
    if (sb.errors == 0) begin
      $display("vehicle_can_signal_decoder_unit: match");
    end else begin
      $display("vehicle_can_signal_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
